/* rtl/ssm_pkg.sv */
// ----------------------------------------------------------------------------
// ssm_pkg: shared types, character codes and classifiers
// Holds the command word passed from the front to the back of the minifier
// and the character class functions used by the front.
// ----------------------------------------------------------------------------
package ssm_pkg;

	// Width of a released-space count: up to a full hold plus one, at most 9
	localparam int SpcW = 4;

	// Character codes
	localparam logic [7:0] ChNul       = 8'h00;
	localparam logic [7:0] ChTab       = 8'h09;
	localparam logic [7:0] ChLf        = 8'h0A;
	localparam logic [7:0] ChCr        = 8'h0D;
	localparam logic [7:0] ChSpace     = 8'h20;
	localparam logic [7:0] ChHash      = 8'h23;
	localparam logic [7:0] ChAmp       = 8'h26;
	localparam logic [7:0] ChLParen    = 8'h28;
	localparam logic [7:0] ChRParen    = 8'h29;
	localparam logic [7:0] ChStar      = 8'h2A;
	localparam logic [7:0] ChPlus      = 8'h2B;
	localparam logic [7:0] ChComma     = 8'h2C;
	localparam logic [7:0] ChMinus     = 8'h2D;
	localparam logic [7:0] ChSlash     = 8'h2F;
	localparam logic [7:0] ChSemi      = 8'h3B;
	localparam logic [7:0] ChLess      = 8'h3C;
	localparam logic [7:0] ChEqual     = 8'h3D;
	localparam logic [7:0] ChGreater   = 8'h3E;
	localparam logic [7:0] ChLBracket  = 8'h5B;
	localparam logic [7:0] ChBackslash = 8'h5C;
	localparam logic [7:0] ChRBracket  = 8'h5D;
	localparam logic [7:0] ChLowerN    = 8'h6E;
	localparam logic [7:0] ChLBrace    = 8'h7B;
	localparam logic [7:0] ChBar       = 8'h7C;
	localparam logic [7:0] ChRBrace    = 8'h7D;

	// What follows the released spaces of one transaction
	typedef enum logic [1:0] {
		BODY_NONE,
		BODY_CHAR,
		BODY_ESC
	} body_t;

	// One command: spaces first, then the body, then an end marker if needed
	typedef struct packed {
		logic [SpcW-1:0] spaces;
		body_t           body;
		logic [7:0]      ch;
		logic            last;
	} ssm_cmd_t;

	function automatic logic is_newline(input logic [7:0] c);
		return (c == ChCr) || (c == ChLf);
	endfunction

	function automatic logic is_white(input logic [7:0] c);
		return (c == ChSpace) || (c == ChTab) || is_newline(c);
	endfunction

	function automatic logic is_operator(input logic [7:0] c);
		logic r;
		case (c) inside
			ChPlus, ChMinus, ChStar, ChSlash, ChEqual, ChSemi,
			ChLParen, ChRParen, ChLBrace, ChRBrace, ChComma, ChBar,
			ChAmp, ChLess, ChGreater: r = 1'b1;
			default: r = 1'b0;
		endcase
		return r;
	endfunction

	function automatic logic is_breaker(input logic [7:0] c);
		return is_operator(c) || (c == ChLBracket) || (c == ChRBracket) || is_white(c);
	endfunction

endpackage

/* rtl/ssm_front.sv */
// ----------------------------------------------------------------------------
// ssm_front: character classifier
// Tracks comment, directive and squeeze state and the held space count, and
// turns each accepted character into at most one command for the back end.
// ----------------------------------------------------------------------------
module ssm_front #(
	parameter int SPACE_HOLD = 8
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	output logic              in_ready,
	input  logic [7:0]        in_char,
	input  logic [7:0]        next_char,
	input  logic              end_of_text,
	input  logic              q_full,
	output logic              push,
	output ssm_pkg::ssm_cmd_t cmd
);
	import ssm_pkg::*;

	localparam int HW = $clog2(SPACE_HOLD + 1);

	logic          lc_q, bc_q, dir_q, sq_q;
	logic [7:0]    prev_q;
	logic [HW-1:0] held_q;

	logic          lc1, bc1, dir1, skip;
	logic          bc_n, dir_n, sq_n;
	logic [HW-1:0] h1, h_n;
	logic [7:0]    nxt;
	logic [SpcW-1:0] sp;
	body_t         body;
	logic          accept;

	assign in_ready = !q_full;
	assign accept   = in_valid && in_ready;

	// Classify the character and work out the next state
	always_comb begin
		nxt  = end_of_text ? ChNul : next_char;
		lc1  = lc_q | ((in_char == ChSlash) && (nxt == ChSlash));
		bc1  = bc_q | ((in_char == ChSlash) && (nxt == ChStar));
		dir1 = dir_q | (in_char == ChHash);
		if (is_newline(in_char)) begin
			lc1 = 1'b0;
		end
		skip  = !dir1 && sq_q && is_white(in_char);
		dir_n = dir1;
		sq_n  = sq_q;
		bc_n  = bc1;
		h1    = held_q;
		h_n   = held_q;
		sp    = '0;
		body  = BODY_NONE;
		if (!skip) begin
			if (is_newline(in_char)) begin
				dir_n = 1'b0;
			end
			sq_n = bc1 | lc1 | is_breaker(in_char);
			// withdraw one held space before an operator
			if (sq_n && (held_q != '0) && is_operator(in_char)) begin
				h1 = held_q - 1'b1;
			end
			h_n = h1;
			if (!lc1 && !bc1) begin
				if (in_char == ChSpace) begin
					if (h1 < HW'(SPACE_HOLD)) begin
						h_n = h1 + 1'b1;
					end else begin
						sp = SpcW'(1);
					end
				end else begin
					sp   = SpcW'(h1);
					h_n  = '0;
					body = is_newline(in_char) ? BODY_ESC : BODY_CHAR;
				end
			end
			if (bc1 && (in_char == ChSlash) && (prev_q == ChStar)) begin
				bc_n = 1'b0;
			end
		end
		// release everything still held at the end of the text
		if (end_of_text) begin
			sp = sp + SpcW'(h_n);
		end
		cmd.spaces = sp;
		cmd.body   = body;
		cmd.ch     = in_char;
		cmd.last   = end_of_text;
		push = accept && ((sp != '0) || (body != BODY_NONE) || end_of_text);
	end

	// Update state on each transaction; return to reset after the last one
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			lc_q   <= 1'b0;
			bc_q   <= 1'b0;
			dir_q  <= 1'b0;
			sq_q   <= 1'b1;
			prev_q <= ChNul;
			held_q <= '0;
		end else if (accept) begin
			if (end_of_text) begin
				lc_q   <= 1'b0;
				bc_q   <= 1'b0;
				dir_q  <= 1'b0;
				sq_q   <= 1'b1;
				prev_q <= ChNul;
				held_q <= '0;
			end else begin
				lc_q   <= lc1;
				bc_q   <= bc_n;
				dir_q  <= dir_n;
				sq_q   <= sq_n;
				prev_q <= in_char;
				held_q <= h_n;
			end
		end
	end

endmodule

/* rtl/ssm_queue.sv */
// ----------------------------------------------------------------------------
// ssm_queue: command queue
// Small register queue that decouples the classifier from the serializer.
// ----------------------------------------------------------------------------
module ssm_queue #(
	parameter int DEPTH = 4
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              push,
	input  ssm_pkg::ssm_cmd_t push_cmd,
	output logic              full,
	input  logic              pop,
	output logic              head_valid,
	output ssm_pkg::ssm_cmd_t head_cmd
);
	import ssm_pkg::*;

	localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CW = $clog2(DEPTH + 1);

	ssm_cmd_t      mem_q [DEPTH];
	logic [PW-1:0] wr_q, rd_q;
	logic [CW-1:0] cnt_q;

	assign full       = (cnt_q == CW'(DEPTH));
	assign head_valid = (cnt_q != '0);
	assign head_cmd   = mem_q[rd_q];

	// Store pushed commands
	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_q] <= push_cmd;
		end
	end

	// Advance pointers and occupancy
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= '0;
			rd_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (push) begin
				wr_q <= (wr_q == PW'(DEPTH - 1)) ? '0 : wr_q + 1'b1;
			end
			if (pop) begin
				rd_q <= (rd_q == PW'(DEPTH - 1)) ? '0 : rd_q + 1'b1;
			end
			if (push && !pop) begin
				cnt_q <= cnt_q + 1'b1;
			end else if (pop && !push) begin
				cnt_q <= cnt_q - 1'b1;
			end
		end
	end

endmodule

/* rtl/ssm_back.sv */
// ----------------------------------------------------------------------------
// ssm_back: result serializer
// Expands the head command into its results, one per cycle, into an output
// register that holds while the consumer stalls.
// ----------------------------------------------------------------------------
module ssm_back (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              head_valid,
	input  ssm_pkg::ssm_cmd_t head_cmd,
	output logic              pop,
	output logic              out_valid,
	input  logic              out_ready,
	output logic [7:0]        out_char,
	output logic              char_valid,
	output logic              final_result
);
	import ssm_pkg::*;

	logic [SpcW-1:0] pos_q;
	logic [SpcW-1:0] body_len, total;
	logic            marker, emit, is_end;
	logic [7:0]      r_char;
	logic            r_valid;
	logic            out_valid_q;

	assign out_valid = out_valid_q;

	// Pick the result at the current position of the head command
	always_comb begin
		marker = head_cmd.last && (head_cmd.spaces == '0) && (head_cmd.body == BODY_NONE);
		unique case (head_cmd.body)
			BODY_CHAR: body_len = SpcW'(1);
			BODY_ESC:  body_len = SpcW'(2);
			default:   body_len = '0;
		endcase
		total   = head_cmd.spaces + body_len + SpcW'(marker);
		is_end  = (pos_q == total - 1'b1);
		r_valid = 1'b1;
		if (pos_q < head_cmd.spaces) begin
			r_char = ChSpace;
		end else if (head_cmd.body == BODY_CHAR) begin
			r_char = head_cmd.ch;
		end else if (head_cmd.body == BODY_ESC) begin
			r_char = (pos_q == head_cmd.spaces) ? ChBackslash : ChLowerN;
		end else begin
			r_char  = ChNul;
			r_valid = 1'b0;
		end
		emit = head_valid && (!out_valid_q || out_ready);
		pop  = emit && is_end;
	end

	// Step through the results of the head command
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q       <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (emit) begin
				pos_q <= is_end ? '0 : pos_q + 1'b1;
			end
			if (emit) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// Load the output register
	always_ff @(posedge clk) begin
		if (emit) begin
			out_char     <= r_char;
			char_valid   <= r_valid;
			final_result <= head_cmd.last && is_end;
		end
	end

endmodule

/* rtl/shader_source_minifier_core.sv */
// ----------------------------------------------------------------------------
// shader_source_minifier_core: shader source minifier
// Strips comments and squeezes whitespace from a character stream, holding
// trailing spaces so that a following operator can withdraw one.
//
//   channel | handshake           | fields
//   --------+---------------------+-------------------------------------
//   input   | in_valid/in_ready   | in_char, next_char, end_of_text
//   output  | out_valid/out_ready | out_char, char_valid, final_result
//
// One character is taken per cycle while the command queue has room.
// Each character yields 0 to SPACE_HOLD+2 results, sent one per cycle by
// the serializer, so sustained rate is set by the results per character.
// Results are registered at the output. Reset clears the state and empties
// the queue; an output stall holds the output register and fills the queue.
// ----------------------------------------------------------------------------
module shader_source_minifier_core #(
	parameter int SPACE_HOLD  = 8,
	parameter int QUEUE_DEPTH = 4
) (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       in_valid,
	output logic       in_ready,
	input  logic [7:0] in_char,
	input  logic [7:0] next_char,
	input  logic       end_of_text,
	output logic       out_valid,
	input  logic       out_ready,
	output logic [7:0] out_char,
	output logic       char_valid,
	output logic       final_result
);
	import ssm_pkg::*;

	logic     q_full, q_push, q_pop, q_valid;
	ssm_cmd_t q_in, q_head;

	// Classify incoming characters
	ssm_front #(
		.SPACE_HOLD(SPACE_HOLD)
	) u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (in_valid),
		.in_ready   (in_ready),
		.in_char    (in_char),
		.next_char  (next_char),
		.end_of_text(end_of_text),
		.q_full     (q_full),
		.push       (q_push),
		.cmd        (q_in)
	);

	// Buffer commands between the two halves
	ssm_queue #(
		.DEPTH(QUEUE_DEPTH)
	) u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (q_push),
		.push_cmd  (q_in),
		.full      (q_full),
		.pop       (q_pop),
		.head_valid(q_valid),
		.head_cmd  (q_head)
	);

	// Serialize results
	ssm_back u_back (
		.clk         (clk),
		.arst_n      (arst_n),
		.head_valid  (q_valid),
		.head_cmd    (q_head),
		.pop         (q_pop),
		.out_valid   (out_valid),
		.out_ready   (out_ready),
		.out_char    (out_char),
		.char_valid  (char_valid),
		.final_result(final_result)
	);

	// A bare end marker only ever closes the text
	a_marker_final: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !char_valid |-> final_result)
		else $error("end marker without final flag");

	// The classifier never pushes into a full queue
	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		q_push |-> !q_full)
		else $error("command queue overflow");

	// The serializer only retires a command that is present
	a_no_underflow: assert property (@(posedge clk) disable iff (!arst_n)
		q_pop |-> q_valid)
		else $error("command queue underflow");

endmodule
